// ===== hw/rtl/fadd_pkg.sv =====
// ----------------------------------------------------------------------------
// fadd_pkg
// shared constants and types for the single-precision adder pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package fadd_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned MagWidth  = 27;

   localparam logic [MagWidth-1:0] HiddenOne = MagWidth'(32'd8388608);
   localparam logic [MagWidth-1:0] MantMax   = MagWidth'(32'd16777215);

   // result of the align stage
   typedef struct packed {
      logic                 sign;
      logic                 same_sign;
      logic                 bypass;
      logic [WordWidth-1:0] big_word;
      logic [ExpWidth-1:0]  exp;
      logic [FracWidth-1:0] big_frac;
      logic [MagWidth-1:0]  small_mag;
      logic                 sticky;
   } align_type;

   // result of the add stage, before normalisation
   typedef struct packed {
      logic                 sign;
      logic                 same_sign;
      logic                 bypass;
      logic [WordWidth-1:0] big_word;
      logic [ExpWidth-1:0]  exp;
      logic [MagWidth-1:0]  mag;
      logic                 sticky;
      logic [4:0]           lz;
   } addsub_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fadd_round.sv =====
// ----------------------------------------------------------------------------
// fadd_round
// normalisation and rounding of the raw sum or difference
// ----------------------------------------------------------------------------
`default_nettype none

module fadd_round (
   input  var fadd_pkg::addsub_type    addsub,
   output logic [fadd_pkg::WordWidth-1:0] result
);
   import fadd_pkg::*;

   logic [MagWidth-1:0] m;
   logic [MagWidth-1:0] t;
   logic [9:0]          ex;
   logic [2:0]          rb;
   logic [MagWidth-1:0] norm;

   always_comb begin
      m  = addsub.mag;
      ex = {2'b00, addsub.exp};
      t  = '0;
      rb = '0;
      norm = m << addsub.lz;
      if (addsub.bypass) begin
         result = addsub.big_word;
      end else if (addsub.same_sign) begin
         if ((m >> 2) > MantMax) begin
            rb = m[2:0];
            t = m;
            if (rb > 3'd4 || (rb == 3'd4 && (addsub.sticky || m[3]))) begin
               t = m + MagWidth'(8);
            end
            t = t >> 3;
            ex = ex + 10'd1;
         end else begin
            rb = {1'b0, m[1:0]};
            t = m;
            if (rb > 3'd2 || (rb == 3'd2 && (addsub.sticky || m[2]))) begin
               t = m + MagWidth'(4);
            end
            t = t >> 2;
            if (t > MantMax) begin
               t = t >> 1;
               ex = ex + 10'd1;
            end
         end
         result = {addsub.sign, ex[7:0], t[FracWidth-1:0]};
      end else begin
         if ((m >> 1) < HiddenOne) begin
            if (m == '0) begin
               ex = '0;
               t = '0;
            end else begin
               ex = ex - 10'd2 - {5'd0, addsub.lz};
               t = norm;
            end
         end else if ((m >> 2) < HiddenOne) begin
            t = m;
            if (m[0] && !addsub.sticky && m[1]) begin
               t = m + MagWidth'(2);
            end
            if ((t >> 2) < HiddenOne) begin
               t = t >> 1;
               ex = ex - 10'd1;
            end else begin
               t = t >> 2;
            end
         end else begin
            rb = {1'b0, m[1:0]};
            t = m;
            if (rb > 3'd2 || (rb == 3'd2 && !addsub.sticky && m[2])) begin
               t = m + MagWidth'(4);
            end
            t = t >> 2;
         end
         if (ex[9]) begin
            ex = '0;
            t = '0;
         end
         result = {addsub.sign, ex[7:0], t[FracWidth-1:0]};
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/float32_adder_bit_exact.sv =====
// pipeline: four register stages, big_ff, al_ff, as_ff, res_ff; res_ff drives rsp_sum_bits
// throughput: one item per cycle unless stalled; compare, align, add, round each own a stage
// stall: a stage advances when the stage after it is empty or moving
// reset: synchronous, active high; clears the valid bits only
// no pipeline memory, so the block is ready right after reset
// ----------------------------------------------------------------------------
// float32_adder_bit_exact
// four-stage pipelined single-precision adder on raw bit patterns
// ----------------------------------------------------------------------------
`default_nettype none

module float32_adder_bit_exact (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [fadd_pkg::WordWidth-1:0] req_operand_a,
   input  logic [fadd_pkg::WordWidth-1:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [fadd_pkg::WordWidth-1:0] rsp_sum_bits
);
   import fadd_pkg::*;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic go1, go2, go3, go4;

   // stage 1: ordered operands
   logic [WordWidth-1:0] big_ff, small_ff, big_in, small_in;
   // stage 2: aligned
   align_type al_ff, al_in;
   // stage 3: raw sum with leading-zero count
   addsub_type as_ff, as_in;
   // stage 4: result
   logic [WordWidth-1:0] res_ff, res_in;

   assign go4 = !v4_ff || rsp_ready;
   assign go3 = !v3_ff || go4;
   assign go2 = !v2_ff || go3;
   assign go1 = !v1_ff || go2;
   assign req_ready = go1;
   assign rsp_valid = v4_ff;
   assign rsp_sum_bits = res_ff;

   // order by magnitude, exponent then fraction
   always_comb begin
      if (req_operand_a[30:0] < req_operand_b[30:0]) begin
         big_in = req_operand_b;
         small_in = req_operand_a;
      end else begin
         big_in = req_operand_a;
         small_in = req_operand_b;
      end
   end

   // alignment with two guard bits and sticky
   logic [ExpWidth-1:0] exp_diff;
   logic [MagWidth-1:0] ms;
   logic [4:0]          k;
   always_comb begin
      exp_diff = big_ff[30:23] - small_ff[30:23];
      ms = HiddenOne + MagWidth'(small_ff[22:0]);
      k = '0;
      al_in.sign = big_ff[31];
      al_in.same_sign = big_ff[31] == small_ff[31];
      al_in.bypass = small_ff[30:0] == '0;
      al_in.big_word = big_ff;
      al_in.exp = big_ff[30:23];
      al_in.big_frac = big_ff[22:0];
      if (exp_diff < 8'd2) begin
         al_in.small_mag = ms << (2 - exp_diff[0]);
         al_in.sticky = 1'b0;
      end else if (exp_diff < 8'd26) begin
         k = 5'(exp_diff - 8'd2);
         al_in.small_mag = ms >> k;
         al_in.sticky = (ms & ((MagWidth'(1) << k) - MagWidth'(1))) != '0;
      end else begin
         al_in.small_mag = '0;
         al_in.sticky = small_ff[22:0] != '0;
      end
   end

   // add or subtract, and count shifts needed to reach the hidden one
   logic [MagWidth-1:0] bigm;
   always_comb begin
      bigm = (HiddenOne + MagWidth'(al_ff.big_frac)) << 2;
      as_in.sign = al_ff.sign;
      as_in.same_sign = al_ff.same_sign;
      as_in.bypass = al_ff.bypass;
      as_in.big_word = al_ff.big_word;
      as_in.exp = al_ff.exp;
      as_in.sticky = al_ff.sticky;
      as_in.mag = al_ff.same_sign ? bigm + al_ff.small_mag : bigm - al_ff.small_mag;
      as_in.lz = '0;
      for (int i = 23; i >= 0; i--) begin
         if (as_in.mag[i] && as_in.mag[MagWidth-1:24] == '0 &&
             (as_in.mag[23:0] >> (i + 1)) == '0) begin
            as_in.lz = 5'(23 - i);
         end
      end
   end

   fadd_round u_round (
      .addsub (as_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (go1) v1_ff <= req_valid;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
         if (go4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go1) begin
         big_ff <= big_in;
         small_ff <= small_in;
      end
      if (go2) al_ff <= al_in;
      if (go3) as_ff <= as_in;
      if (go4) res_ff <= res_in;
   end

endmodule

`default_nettype wire

// ===== tb/sv/float32_adder_bit_exact_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_adder_bit_exact_tb
// drives operand pairs through the adder with bursty input and stalling output,
// and checks each sum bit for bit against a typed-in sum or the local model
// ----------------------------------------------------------------------------
`default_nettype none

module float32_adder_bit_exact_tb;

   import fadd_pkg::*;

   localparam int unsigned NumRandom  = 1400;
   localparam int unsigned IdleLimit  = 2000;
   localparam int unsigned DrainWait  = 12;
   localparam logic [31:0] NoSum      = 32'h0;

   // directed row: operands, typed-in sum, and whether that sum is given
   typedef struct {
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] b;
      logic [WordWidth-1:0] sum;
      bit                   known;
   } vector_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [WordWidth-1:0] req_operand_a = '0;
   logic [WordWidth-1:0] req_operand_b = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WordWidth-1:0] rsp_sum_bits;

   logic [WordWidth-1:0] sum_queue[$];
   int unsigned          error_count = 0;
   int unsigned          idle_cycles = 0;
   bit                   stimulus_done = 1'b0;

   vector_type vectors[] = '{
      // zero on either side gives the other operand back, sign and all
      '{32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000, 1'b1},
      '{32'h0000_0000, 32'hBF80_0000, 32'hBF80_0000, 1'b1},
      '{32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1},
      '{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1},
      // 1 + 1 = 2, 1 - 1 cancels exactly to +0, -1 + 1 to -0
      '{32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000, 1'b1},
      '{32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000 & 32'h0, 1'b1},
      '{32'hBF80_0000, 32'h3F80_0000, 32'h8000_0000, 1'b1},
      // all-ones patterns, nan and infinity treated as plain numbers
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, NoSum, 1'b0},
      '{32'h7FFF_FFFF, 32'hFFFF_FFFF, NoSum, 1'b0},
      '{32'h7F80_0000, 32'h7F80_0000, NoSum, 1'b0},
      '{32'h7F80_0000, 32'hFF80_0000, NoSum, 1'b0},
      // exponent overflow is not caught: the sum's exponent field reaches all ones
      '{32'h7F7F_FFFF, 32'h7F7F_FFFF, NoSum, 1'b0},
      '{32'h7F7F_FFFF, 32'h7300_0000, NoSum, 1'b0},
      // exponent zero with fraction keeps the hidden one
      '{32'h0000_0001, 32'h0000_0001, NoSum, 1'b0},
      '{32'h007F_FFFF, 32'h8000_0001, NoSum, 1'b0},
      // subtraction underflow flushes
      '{32'h0080_0000, 32'h807F_FFFF, NoSum, 1'b0},
      '{32'h0000_0003, 32'h8000_0001, NoSum, 1'b0},
      // large alignment distance, sticky from the fraction alone
      '{32'h4B00_0000, 32'h3300_0001, NoSum, 1'b0},
      '{32'h4B00_0000, 32'hB300_0001, NoSum, 1'b0},
      '{32'h7F00_0000, 32'h0000_0001, NoSum, 1'b0},
      // carry out and rounding ties
      '{32'h3FFF_FFFF, 32'h3400_0000, NoSum, 1'b0},
      '{32'h4B7F_FFFF, 32'h3F00_0000, NoSum, 1'b0},
      '{32'h3F80_0001, 32'hB380_0000, NoSum, 1'b0},
      '{32'h3F80_0000, 32'hB300_0001, NoSum, 1'b0},
      '{32'h4000_0001, 32'hBF80_0001, NoSum, 1'b0}
   };

   float32_adder_bit_exact uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sum_bits  (rsp_sum_bits)
   );

   always #6 clock = ~clock;

   // model of the adder: order by magnitude, align with two guard bits and a
   // sticky bit, add or subtract, then round the way the hardware does
   function automatic logic [31:0] fadd_sum(logic [31:0] a, logic [31:0] b);
      logic [31:0] big, lesser, mag, ex, rb, ms, k;
      logic        sg, stk;
      logic [7:0]  ea, eb, eg, es;
      logic [22:0] fa, fb, fg, fs;
      logic [31:0] shift_dist;
      big = a;
      lesser = b;
      ea = a[30:23]; fa = a[22:0];
      eb = b[30:23]; fb = b[22:0];
      if (ea < eb || (ea == eb && fa < fb)) begin
         big = b;
         lesser = a;
      end
      sg = big[31];
      eg = big[30:23];
      fg = big[22:0];
      es = lesser[30:23];
      fs = lesser[22:0];
      if (es == 0 && fs == 0)
         return big;
      shift_dist = 32'(eg) - 32'(es);
      ms = 32'h80_0000 + 32'(fs);
      if (shift_dist < 2) begin
         mag = ms << (2 - shift_dist);
         stk = 1'b0;
      end else if (shift_dist < 26) begin
         k = shift_dist - 2;
         mag = ms >> k;
         stk = (ms & ((32'd1 << k) - 1)) != 0;
      end else begin
         mag = 0;
         stk = fs != 0;
      end
      ex = 32'(eg);
      if (sg == lesser[31]) begin
         mag += (32'h80_0000 + 32'(fg)) << 2;
         if ((mag >> 2) > 32'hFF_FFFF) begin
            rb = mag & 7;
            if (rb > 4 || (rb == 4 && (stk || mag[3])))
               mag += 8;
            mag >>= 3;
            ex += 1;
         end else begin
            rb = mag & 3;
            if (rb > 2 || (rb == 2 && (stk || mag[2])))
               mag += 4;
            mag >>= 2;
            if (mag > 32'hFF_FFFF) begin
               mag >>= 1;
               ex += 1;
            end
         end
         return {sg, ex[7:0], mag[22:0]};
      end
      mag = ((32'h80_0000 + 32'(fg)) << 2) - mag;
      if ((mag >> 1) < 32'h80_0000) begin
         ex -= 2;
         if (mag == 0) begin
            ex = 0;
         end else begin
            while (mag < 32'h80_0000) begin
               mag <<= 1;
               ex -= 1;
            end
         end
      end else if ((mag >> 2) < 32'h80_0000) begin
         if (mag[0] && !stk && mag[1])
            mag += 2;
         if ((mag >> 2) < 32'h80_0000) begin
            mag >>= 1;
            ex -= 1;
         end else begin
            mag >>= 2;
         end
      end else begin
         rb = mag & 3;
         if (rb > 2 || (rb == 2 && !stk && mag[2]))
            mag += 4;
         mag >>= 2;
      end
      // wrapped below zero: flush
      if (ex > 256) begin
         ex = 0;
         mag = 0;
      end
      return {sg, ex[7:0], mag[22:0]};
   endfunction

   // operand with a random exponent bias so that close exponents are common
   function automatic logic [31:0] pick_operand(logic [31:0] other);
      logic [31:0] v;
      int unsigned mode;
      v = $urandom;
      mode = $urandom_range(0, 9);
      if (mode < 4)
         v[30:23] = 8'(int'(other[30:23]) + $urandom_range(0, 6) - 3);
      else if (mode == 4)
         v[30:0] = 31'h0;
      else if (mode == 5)
         v[22:0] = $urandom_range(0, 1) ? 23'h7F_FFFF : 23'h0;
      else if (mode == 6)
         v[30:0] = other[30:0] ^ 31'($urandom_range(0, 3));
      return v;
   endfunction

   // present one item and hold it until the adder takes it
   task automatic send_item(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] expected);
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      sum_queue.push_back(expected);
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // count down a running burst; once it ends, idle the sender for a random gap, then hand back a new burst length
   task automatic sender_gap(inout int burst);
      int gap;
      if (burst > 0) begin
         burst--;
         return;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst = $urandom_range(1, 40);
   endtask

   // stimulus
   initial begin
      logic [31:0] a, b;
      int          burst;
      burst = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rows with a typed-in sum are checked against that sum directly
      foreach (vectors[i]) begin
         sender_gap(burst);
         if (vectors[i].known)
            send_item(vectors[i].a, vectors[i].b, vectors[i].sum);
         else
            send_item(vectors[i].a, vectors[i].b, fadd_sum(vectors[i].a, vectors[i].b));
      end

      for (int n = 0; n < NumRandom; n++) begin
         sender_gap(burst);
         a = $urandom;
         b = pick_operand(a);
         if ($urandom_range(0, 1))
            send_item(a, b, fadd_sum(a, b));
         else
            send_item(b, a, fadd_sum(b, a));
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // receiver stalls on its own pattern: long open stretches, then choppy ones
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (phase % 256 < 96)
            rsp_ready <= 1'b1;
         else if (phase % 256 < 200)
            rsp_ready <= $urandom_range(0, 2) != 0;
         else
            rsp_ready <= $urandom_range(0, 4) == 0;
      end
   end

   // compare each sum with the oldest expected one
   always @(posedge clock) begin
      logic [31:0] expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sum_queue.size() == 0) begin
            $display("%0t: unexpected sum: expected none, actual %h", $time, rsp_sum_bits);
            error_count++;
         end else begin
            expected = sum_queue.pop_front();
            if (rsp_sum_bits !== expected) begin
               $display("%0t: sum_bits mismatch: expected %h, actual %h",
                        $time, expected, rsp_sum_bits);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // end of run
   initial begin
      wait (stimulus_done);
      while (sum_queue.size() != 0 && idle_cycles < IdleLimit)
         @(posedge clock);
      if (sum_queue.size() != 0) begin
         $display("*** FAILED ***");
      end else begin
         repeat (DrainWait) @(posedge clock);
         if (error_count == 0)
            $display("*** PASSED ***");
         else
            $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog during stimulus
   initial begin
      wait (idle_cycles >= IdleLimit && !stimulus_done);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// ===== float32_adder_bit_exact.f =====
hw/rtl/fadd_pkg.sv
hw/rtl/fadd_round.sv
hw/rtl/float32_adder_bit_exact.sv
tb/sv/float32_adder_bit_exact_tb.sv
